// ===== hdl/srft_pkg.sv =====
// Shared types, constants and controller/datapath interface of the session relay table.
package srft_pkg;

  // Default table geometry
  localparam int unsigned SessionsDefault = 16;
  localparam int unsigned MembersDefault  = 8;

  // Configuration port
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_MAGIC_TOKEN      = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LENGTH       = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_SECONDS  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLEANUP_INTERVAL = 8'd3;

  // Register reset values
  localparam logic [63:0] MagicReset   = 64'hDEAD_BEEF_CAFE_BABE;
  localparam logic [15:0] MinLenReset  = 16'd24;
  localparam logic [16:0] TimeoutReset = 17'd60;
  localparam logic [19:0] IntervalReset = 20'd1000;

  // Result status codes
  typedef enum logic [2:0] {
    ST_FWD       = 3'd0,
    ST_RX_ERR    = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_TOKEN = 3'd3,
    ST_NO_PEERS  = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;      // latch input transaction, advance reception count
    logic idx_clr;     // restart the session index
    logic sw_eval;     // aging check of the session just read
    logic lk_eval;     // lookup check of the session just read
    logic lk_commit;   // claim/refresh the chosen session
    logic mb_eval;     // compare the member just read with the sender
    logic mb_add;      // store the sender if new and room left
    logic em_eval;     // consider the member just read as a target
    logic one_load;    // load a single non-target result
    logic final_load;  // load the closing result
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic sweep_need;
    logic drop;
    logic idx_last;
    logic hit;         // session matched or free slot found
    logic m_end;       // member index reached the member count
    logic cap;         // target limit reached
    logic push_need;   // a held target must go out before the next one
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/srft_ctrl.sv =====
// Controller state machine sequencing sweep, lookup, member update and target emission.
module srft_ctrl import srft_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SW_RD  = 14'b00000000000010,
    S_SW_CMP = 14'b00000000000100,
    S_CHECK  = 14'b00000000001000,
    S_LK_RD  = 14'b00000000010000,
    S_LK_CMP = 14'b00000000100000,
    S_LK_END = 14'b00000001000000,
    S_MB_RD  = 14'b00000010000000,
    S_MB_CMP = 14'b00000100000000,
    S_MB_ADD = 14'b00001000000000,
    S_EM_RD  = 14'b00010000000000,
    S_EM_CMP = 14'b00100000000000,
    S_FINAL  = 14'b01000000000000,
    S_ONE    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.sweep_need ? S_SW_RD : S_CHECK;
        end
      end
      S_SW_RD: state_d = S_SW_CMP;
      S_SW_CMP: begin
        cmd_o.sw_eval = 1'b1;
        state_d = sts_i.idx_last ? S_CHECK : S_SW_RD;
      end
      S_CHECK: begin
        cmd_o.idx_clr = 1'b1;
        state_d = sts_i.drop ? S_ONE : S_LK_RD;
      end
      S_LK_RD: state_d = S_LK_CMP;
      S_LK_CMP: begin
        cmd_o.lk_eval = 1'b1;
        state_d = sts_i.idx_last ? S_LK_END : S_LK_RD;
      end
      S_LK_END: begin
        if (sts_i.hit) begin
          cmd_o.lk_commit = 1'b1;
          state_d = S_MB_RD;
        end else begin
          state_d = S_ONE;
        end
      end
      S_MB_RD: state_d = sts_i.m_end ? S_MB_ADD : S_MB_CMP;
      S_MB_CMP: begin
        cmd_o.mb_eval = 1'b1;
        state_d = S_MB_RD;
      end
      S_MB_ADD: begin
        cmd_o.mb_add = 1'b1;
        state_d = S_EM_RD;
      end
      S_EM_RD: state_d = (sts_i.m_end || sts_i.cap) ? S_FINAL : S_EM_CMP;
      S_EM_CMP: begin
        if (!sts_i.push_need || sts_i.out_free) begin
          cmd_o.em_eval = 1'b1;
          state_d = S_EM_RD;
        end
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.final_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ONE: begin
        if (sts_i.out_free) begin
          cmd_o.one_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/srft_dp.sv =====
// Datapath: config registers, session and member memories, scan registers, result register.
module srft_dp import srft_pkg::*; #(
  parameter int unsigned SESSIONS = SessionsDefault,
  parameter int unsigned MEMBERS_PER_SESSION = MembersDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                mode_i,
  input  logic [63:0]         session_hi_i,
  input  logic [63:0]         session_lo_i,
  input  logic [63:0]         token_i,
  input  logic [15:0]         packet_length_i,
  input  logic [31:0]         sender_ip_i,
  input  logic [15:0]         sender_port_i,
  input  logic [31:0]         now_seconds_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [31:0]         peer_ip_o,
  output logic [15:0]         peer_port_o,
  output logic                sender_not_stored_o,
  output logic                last_o
);

  localparam int unsigned SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int unsigned MW = $clog2(MEMBERS_PER_SESSION + 1);
  localparam int unsigned MD = SESSIONS * MEMBERS_PER_SESSION;
  localparam int unsigned AW = (MD > 1) ? $clog2(MD) : 1;

  typedef struct packed {
    logic [63:0]   hi;
    logic [63:0]   lo;
    logic [31:0]   seen;
    logic [MW-1:0] cnt;
  } sent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
  } ment_t;

  // Configuration registers
  logic [63:0] magic_q;
  logic [15:0] min_len_q;
  logic [16:0] timeout_q;
  logic [19:0] interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= MagicReset;
      min_len_q  <= MinLenReset;
      timeout_q  <= TimeoutReset;
      interval_q <= IntervalReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAGIC_TOKEN:      magic_q    <= cfg_data_i;
        CFG_MIN_LENGTH:       min_len_q  <= cfg_data_i[15:0];
        CFG_TIMEOUT_SECONDS:  timeout_q  <= cfg_data_i[16:0];
        CFG_CLEANUP_INTERVAL: interval_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // Latched input transaction
  logic        mode_q;
  logic [63:0] key_hi_q, key_lo_q, token_q;
  logic [15:0] len_q;
  ment_t       snd_q;
  logic [31:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= mode_i;
      key_hi_q <= session_hi_i;
      key_lo_q <= session_lo_i;
      token_q  <= token_i;
      len_q    <= packet_length_i;
      snd_q    <= '{ip: sender_ip_i, port: sender_port_i};
      now_q    <= now_seconds_i;
    end
  end

  // Reception counter
  logic [19:0] rcount_q;
  logic [20:0] rnext;
  assign rnext = {1'b0, rcount_q} + 21'd1;
  assign sts_o.sweep_need = rnext > {1'b0, interval_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcount_q <= '0;
    end else if (cmd_i.accept) begin
      rcount_q <= sts_o.sweep_need ? 20'd0 : rnext[19:0];
    end
  end

  // Drop checks
  assign sts_o.drop = mode_q || (len_q <= min_len_q) || (token_q != magic_q);

  status_e drop_code;
  always_comb begin
    if (mode_q) drop_code = ST_RX_ERR;
    else if (len_q <= min_len_q) drop_code = ST_SHORT;
    else if (token_q != magic_q) drop_code = ST_BAD_TOKEN;
    else drop_code = ST_FULL;
  end

  // Scan registers
  logic [SW-1:0] idx_q, match_q, free_q, sess_q;
  logic          match_v_q, free_v_q;
  logic [MW-1:0] mcnt_q, cnt_q, m_q, found_q;
  logic [AW-1:0] base_q;
  logic          stored_q, nstored_q;
  logic          pend_v_q;
  ment_t         pend_q;
  logic [SESSIONS-1:0] sess_v_q;

  sent_t sess_mem [SESSIONS];
  sent_t srd_q;
  ment_t mem_mem [MD];
  ment_t mrd_q;

  logic [AW-1:0] maddr;
  assign maddr = base_q + AW'(m_q);

  // Registered memory reads
  always_ff @(posedge clk_i) begin
    srd_q <= sess_mem[idx_q];
    mrd_q <= mem_mem[maddr];
  end

  // Session commit selection
  logic [SW-1:0] sel;
  logic [MW-1:0] sel_cnt;
  assign sel     = match_v_q ? match_q : free_q;
  assign sel_cnt = match_v_q ? mcnt_q : '0;

  logic  room;
  assign room = cnt_q < MW'(MEMBERS_PER_SESSION);

  // Session memory write port
  logic          s_we;
  logic [SW-1:0] s_wa;
  sent_t         s_wd;
  always_comb begin
    s_we = cmd_i.lk_commit || (cmd_i.mb_add && !stored_q && room);
    s_wa = cmd_i.lk_commit ? sel : sess_q;
    s_wd = '{hi: key_hi_q, lo: key_lo_q, seen: now_q,
             cnt: cmd_i.lk_commit ? sel_cnt : cnt_q + MW'(1)};
  end

  always_ff @(posedge clk_i) begin
    if (s_we) sess_mem[s_wa] <= s_wd;
  end

  // Member memory write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.mb_add && !stored_q && room) mem_mem[base_q + AW'(cnt_q)] <= snd_q;
  end

  logic [31:0] elapsed;
  logic        key_eq, differ;
  assign elapsed = now_q - srd_q.seen;
  assign key_eq  = (srd_q.hi == key_hi_q) && (srd_q.lo == key_lo_q);
  assign differ  = (mrd_q != snd_q);

  // Session valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_v_q <= '0;
    end else if (cmd_i.sw_eval) begin
      if (sess_v_q[idx_q] && (elapsed > {15'd0, timeout_q})) sess_v_q[idx_q] <= 1'b0;
    end else if (cmd_i.lk_commit) begin
      sess_v_q[sel] <= 1'b1;
    end
  end

  // Scan control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      match_v_q <= 1'b0;
      free_v_q  <= 1'b0;
      pend_v_q  <= 1'b0;
      m_q       <= '0;
      found_q   <= '0;
      stored_q  <= 1'b0;
    end else begin
      if (cmd_i.accept || cmd_i.idx_clr) begin
        idx_q     <= '0;
        match_v_q <= 1'b0;
        free_v_q  <= 1'b0;
      end else if (cmd_i.sw_eval || cmd_i.lk_eval) begin
        idx_q <= idx_q + SW'(1);
      end
      if (cmd_i.lk_eval) begin
        if (sess_v_q[idx_q]) begin
          if (!match_v_q && key_eq) match_v_q <= 1'b1;
        end else if (!free_v_q) begin
          free_v_q <= 1'b1;
        end
      end
      if (cmd_i.lk_commit) begin
        m_q      <= '0;
        stored_q <= 1'b0;
      end else if (cmd_i.mb_add) begin
        m_q      <= '0;
        found_q  <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.mb_eval) begin
        m_q <= m_q + MW'(1);
        if (!differ) stored_q <= 1'b1;
      end else if (cmd_i.em_eval) begin
        m_q <= m_q + MW'(1);
        if (differ) begin
          pend_v_q <= 1'b1;
          found_q  <= found_q + MW'(1);
        end
      end
    end
  end

  // Scan payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lk_eval) begin
      if (sess_v_q[idx_q] && !match_v_q && key_eq) begin
        match_q <= idx_q;
        mcnt_q  <= srd_q.cnt;
      end
      if (!sess_v_q[idx_q] && !free_v_q) free_q <= idx_q;
    end
    if (cmd_i.lk_commit) begin
      sess_q <= sel;
      cnt_q  <= sel_cnt;
      base_q <= AW'(32'(sel) * MEMBERS_PER_SESSION);
    end
    if (cmd_i.mb_add) begin
      nstored_q <= !(stored_q || room);
      if (!stored_q && room) cnt_q <= cnt_q + MW'(1);
    end
    if (cmd_i.em_eval && differ) pend_q <= mrd_q;
  end

  assign sts_o.idx_last  = (idx_q == SW'(SESSIONS - 1));
  assign sts_o.hit       = match_v_q || free_v_q;
  assign sts_o.m_end     = (m_q == cnt_q);
  assign sts_o.cap       = (found_q == MW'(MEMBERS_PER_SESSION - 1));
  assign sts_o.push_need = differ && pend_v_q;
  assign sts_o.out_free  = !out_valid_o || out_ready_i;

  // Result register
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.one_load || cmd_i.final_load || (cmd_i.em_eval && differ && pend_v_q)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.one_load) begin
      status_o            <= sts_o.drop ? drop_code : ST_FULL;
      peer_ip_o           <= '0;
      peer_port_o         <= '0;
      sender_not_stored_o <= 1'b0;
      last_o              <= 1'b1;
    end else if (cmd_i.final_load) begin
      status_o            <= pend_v_q ? ST_FWD : ST_NO_PEERS;
      peer_ip_o           <= pend_v_q ? pend_q.ip : 32'd0;
      peer_port_o         <= pend_v_q ? pend_q.port : 16'd0;
      sender_not_stored_o <= nstored_q;
      last_o              <= 1'b1;
    end else if (cmd_i.em_eval && differ && pend_v_q) begin
      status_o            <= ST_FWD;
      peer_ip_o           <= pend_q.ip;
      peer_port_o         <= pend_q.port;
      sender_not_stored_o <= nstored_q;
      last_o              <= 1'b0;
    end
  end

endmodule

// ===== hdl/session_relay_forwarding_table_core.sv =====
// Top level of the session relay forwarding table.
// Usage: one receive event enters on the input channel (in_valid_i/in_ready_o)
// with its header fields; the block answers with one or more result
// transactions on the output channel (out_valid_o/out_ready_i), the final
// one flagged by last_o. Registers are written over the cfg channel, which
// is always ready; the user must write them only while no event is in
// flight, and the block itself does not enforce this.
// An event is handled one at a time; in_ready_o is high only between events.
// Each event is accepted, runs an aging sweep over all sessions when the
// reception count passes the cleanup interval, and is then checked. A
// dropped event ends with a single result. A valid packet goes on to the
// session lookup over all sessions, claims the session (a full session
// table ends with a single result instead), compares the stored members
// with the sender and inserts it if new and room is left, then emits the
// targets and the closing result. Both table scans read one session entry
// at a time through the registered session memory port, a read state then
// a compare state; the member scans likewise use the member memory port.
// Reset clears all sessions, the reception count and the registers to their
// defaults; no clearing pass is needed. A stalled receiver holds results in
// the output register and the block waits on it without losing targets.
module session_relay_forwarding_table_core import srft_pkg::*; #(
  parameter int unsigned SESSIONS = SessionsDefault,
  parameter int unsigned MEMBERS_PER_SESSION = MembersDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [63:0]         session_hi_i,
  input  logic [63:0]         session_lo_i,
  input  logic [63:0]         token_i,
  input  logic [15:0]         packet_length_i,
  input  logic [31:0]         sender_ip_i,
  input  logic [15:0]         sender_port_i,
  input  logic [31:0]         now_seconds_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [31:0]         peer_ip_o,
  output logic [15:0]         peer_port_o,
  output logic                sender_not_stored_o,
  output logic                last_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  srft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srft_dp #(
    .SESSIONS            (SESSIONS),
    .MEMBERS_PER_SESSION (MEMBERS_PER_SESSION)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .mode_i              (mode_i),
    .session_hi_i        (session_hi_i),
    .session_lo_i        (session_lo_i),
    .token_i             (token_i),
    .packet_length_i     (packet_length_i),
    .sender_ip_i         (sender_ip_i),
    .sender_port_i       (sender_port_i),
    .now_seconds_i       (now_seconds_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .peer_ip_o           (peer_ip_o),
    .peer_port_o         (peer_port_o),
    .sender_not_stored_o (sender_not_stored_o),
    .last_o              (last_o)
  );

  // One event in flight at a time
  a_single_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an event is in flight");

  // Non-target results always close the event
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FWD) |-> last_o)
    else $error("non-target result without last");

  // Non-target results carry no endpoint
  a_status_peer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FWD) |-> (peer_ip_o == 32'd0) && (peer_port_o == 16'd0))
    else $error("non-target result with endpoint");

endmodule

// ===== tb/session_relay_forwarding_table_core_test.sv =====
// Self-checking testbench for the session relay forwarding table core.
`timescale 1ns / 1ps

module session_relay_forwarding_table_core_test;
  import srft_pkg::*;

  localparam int NSESS  = SessionsDefault;
  localparam int NMEMB  = MembersDefault;
  localparam int MAXTGT = NMEMB - 1;

  typedef struct {
    bit          mode;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] token;
    logic [15:0] length;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] now;
  } event_t;

  typedef struct {
    status_e     status;
    logic [31:0] ip;
    logic [15:0] port;
    bit          not_stored;
    bit          last;
  } target_t;

  typedef struct {
    event_t  ev;
    bit      typed;
    status_e status;
    bit      not_stored;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = 1'b0;
  logic [63:0] session_hi_i = '0;
  logic [63:0] session_lo_i = '0;
  logic [63:0] token_i = '0;
  logic [15:0] packet_length_i = '0;
  logic [31:0] sender_ip_i = '0;
  logic [15:0] sender_port_i = '0;
  logic [31:0] now_seconds_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] peer_ip_o;
  logic [15:0] peer_port_o;
  logic        sender_not_stored_o;
  logic        last_o;

  session_relay_forwarding_table_core uut (.*);

  always #6 clk_i = ~clk_i;

  // Predictor copy of registers and table
  logic [63:0] magic;
  logic [15:0] min_len;
  logic [16:0] timeout;
  logic [19:0] interval;
  bit          sess_vld [NSESS];
  logic [63:0] sess_hi  [NSESS];
  logic [63:0] sess_lo  [NSESS];
  logic [31:0] sess_seen[NSESS];
  bit          memb_vld [NSESS*NMEMB];
  logic [31:0] memb_ip  [NSESS*NMEMB];
  logic [15:0] memb_port[NSESS*NMEMB];
  logic [19:0] rx_count;

  target_t fwd_calc[MAXTGT];
  target_t pending_targets[$];

  int snd_idle, rcv_idle;
  int errors = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;

  // Random pools of session keys and endpoints
  logic [63:0] pool_hi[20], pool_lo[20];
  logic [31:0] pool_ip[12];
  logic [15:0] pool_port[12];
  logic [31:0] clock_now;
  int          step_max;

  function automatic target_t mk(status_e st, logic [31:0] ip, logic [15:0] port,
                                 bit ns, bit last);
    target_t t;
    t.status = st; t.ip = ip; t.port = port; t.not_stored = ns; t.last = last;
    return t;
  endfunction

  // Forwarding prediction: updates table state, fills fwd_calc, returns count
  function automatic int forward_targets(event_t ev);
    int sess = -1, freeslot = -1, base, n = 0;
    bit stored = 0;
    if (rx_count + 21'd1 > {1'b0, interval}) begin
      for (int s = 0; s < NSESS; s++)
        if (sess_vld[s] && (ev.now - sess_seen[s]) > {15'd0, timeout}) begin
          sess_vld[s] = 0;
          for (int m = 0; m < NMEMB; m++) memb_vld[s*NMEMB+m] = 0;
        end
      rx_count = '0;
    end else begin
      rx_count = rx_count + 1'b1;
    end
    if (ev.mode) begin
      fwd_calc[0] = mk(ST_RX_ERR, 0, 0, 0, 1); return 1;
    end
    if (ev.length <= min_len) begin
      fwd_calc[0] = mk(ST_SHORT, 0, 0, 0, 1); return 1;
    end
    if (ev.token != magic) begin
      fwd_calc[0] = mk(ST_BAD_TOKEN, 0, 0, 0, 1); return 1;
    end
    for (int s = 0; s < NSESS; s++) begin
      if (sess_vld[s]) begin
        if (sess < 0 && sess_hi[s] == ev.key_hi && sess_lo[s] == ev.key_lo) sess = s;
      end else if (freeslot < 0) begin
        freeslot = s;
      end
    end
    if (sess < 0) begin
      if (freeslot < 0) begin
        fwd_calc[0] = mk(ST_FULL, 0, 0, 0, 1); return 1;
      end
      sess = freeslot;
      sess_vld[sess] = 1;
      sess_hi[sess] = ev.key_hi;
      sess_lo[sess] = ev.key_lo;
      for (int m = 0; m < NMEMB; m++) memb_vld[sess*NMEMB+m] = 0;
    end
    sess_seen[sess] = ev.now;
    base = sess * NMEMB;
    freeslot = -1;
    for (int m = 0; m < NMEMB; m++) begin
      if (memb_vld[base+m]) begin
        if (memb_ip[base+m] == ev.ip && memb_port[base+m] == ev.port) stored = 1;
      end else if (freeslot < 0) begin
        freeslot = m;
      end
    end
    if (!stored && freeslot >= 0) begin
      memb_vld[base+freeslot] = 1;
      memb_ip[base+freeslot] = ev.ip;
      memb_port[base+freeslot] = ev.port;
      stored = 1;
    end
    for (int m = 0; m < NMEMB && n < MAXTGT; m++) begin
      if (memb_vld[base+m]
          && !(memb_ip[base+m] == ev.ip && memb_port[base+m] == ev.port)) begin
        fwd_calc[n] = mk(ST_FWD, memb_ip[base+m], memb_port[base+m], !stored, 0);
        n++;
      end
    end
    if (n == 0) begin
      fwd_calc[0] = mk(ST_NO_PEERS, 0, 0, !stored, 1); return 1;
    end
    fwd_calc[n-1].last = 1;
    return n;
  endfunction

  // Register write over the cfg channel, mirrored into the predictor
  task automatic write_reg(logic [7:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAGIC_TOKEN:      magic = val;
      CFG_MIN_LENGTH:       min_len = val[15:0];
      CFG_TIMEOUT_SECONDS:  timeout = val[16:0];
      CFG_CLEANUP_INTERVAL: interval = val[19:0];
      default: ;
    endcase
  endtask

  // Offer one event; valid stays up across back-to-back transactions
  task automatic send_event(event_t ev, bit typed, status_e st, bit ns);
    int n;
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= ev.mode;
    session_hi_i    <= ev.key_hi;
    session_lo_i    <= ev.key_lo;
    token_i         <= ev.token;
    packet_length_i <= ev.length;
    sender_ip_i     <= ev.ip;
    sender_port_i   <= ev.port;
    now_seconds_i   <= ev.now;
    do @(posedge clk_i); while (!in_ready_o);
    n = forward_targets(ev);
    if (typed) pending_targets = {pending_targets, mk(st, 0, 0, ns, 1)};
    else for (int i = 0; i < n; i++) pending_targets = {pending_targets, fwd_calc[i]};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_targets.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic event_t random_event();
    event_t ev;
    int k = $urandom_range(19), e = $urandom_range(11);
    clock_now += $urandom_range(step_max);
    ev.mode   = 0;
    ev.key_hi = pool_hi[k];
    ev.key_lo = pool_lo[k];
    ev.token  = magic;
    ev.length = (min_len == 16'hFFFF) ? 16'hFFFF
              : 16'(min_len + 1 + $urandom_range(32'hFFFE - min_len));
    ev.ip     = pool_ip[e];
    ev.port   = pool_port[e];
    ev.now    = clock_now;
    // Noise: errors, short packets, bad tokens, stray keys
    if ($urandom_range(99) < 25) begin
      case ($urandom_range(3))
        0: ev.mode = 1;
        1: ev.length = 16'($urandom_range(65535));
        2: ev.token = ($urandom_range(1)) ? {$urandom, $urandom}
                                          : magic ^ (64'd1 << $urandom_range(63));
        default: begin
          ev.key_hi = {$urandom, $urandom};
          ev.key_lo = {$urandom, $urandom};
          ev.ip = $urandom;
          ev.port = 16'($urandom);
          ev.now = $urandom;
        end
      endcase
    end
    return ev;
  endfunction

  task automatic random_phase(int count, int hold_at);
    for (int i = 0; i < 20; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end
    for (int i = 0; i < 12; i++) begin
      pool_ip[i] = $urandom;
      pool_port[i] = 16'($urandom);
    end
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req <= hold_req + 1;
      send_event(random_event(), 0, ST_FWD, 0);
    end
    drain();
  endtask

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random ready and result check
  always @(posedge clk_i or negedge rst_ni) begin
    target_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_targets.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result status=%0d ip=%h", status_o, peer_ip_o);
        end else begin
          want = pending_targets.pop_front();
          if (status_o !== want.status || peer_ip_o !== want.ip || peer_port_o !== want.port
              || sender_not_stored_o !== want.not_stored || last_o !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp st=%0d ip=%h port=%h ns=%b last=%b, ",
                        "got st=%0d ip=%h port=%h ns=%b last=%b"},
                       want.status, want.ip, want.port, want.not_stored, want.last,
                       status_o, peer_ip_o, peer_port_o, sender_not_stored_o, last_o);
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    #20_000_000;
    $display("session_relay_forwarding_table_core regression: fail");
    $finish;
  end

  initial begin
    row_t    dir_tab[$];
    row_t    r;
    event_t  base;
    magic = MagicReset; min_len = MinLenReset; timeout = TimeoutReset;
    interval = IntervalReset; rx_count = '0;
    foreach (sess_vld[i]) sess_vld[i] = 0;
    foreach (memb_vld[i]) memb_vld[i] = 0;
    snd_idle = 23; rcv_idle = 76;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: drops, known sender, member overflow, key and time extremes
    base = '{0, '0, '0, MagicReset, 16'd25, 32'd1, 16'd1, 32'd100};
    r = '{base, 1, ST_RX_ERR, 0};
    r.ev = '{1, '1, '1, '1, 16'hFFFF, '1, '1, '1};          dir_tab = {dir_tab, r};
    r = '{base, 1, ST_SHORT, 0};    r.ev.length = 16'd24;  dir_tab = {dir_tab, r};
    r.ev.length = 16'd0;                                   dir_tab = {dir_tab, r};
    r = '{base, 1, ST_BAD_TOKEN, 0}; r.ev.token = '0;      dir_tab = {dir_tab, r};
    r.ev.token = '1; r.ev.length = 16'hFFFF;               dir_tab = {dir_tab, r};
    r = '{base, 1, ST_NO_PEERS, 0};                        dir_tab = {dir_tab, r};
    dir_tab = {dir_tab, r};                                // same sender again
    r.typed = 0;
    r.ev.ip = '1; r.ev.port = '1;                          dir_tab = {dir_tab, r};
    for (int i = 2; i < 10; i++) begin                     // fill then overflow members
      r.ev.ip = 32'h0A00_0000 + i; r.ev.port = 16'(5000 + i);
      dir_tab = {dir_tab, r};
    end
    r.ev.ip = '0; r.ev.port = '0;                          dir_tab = {dir_tab, r};
    r.ev.key_hi = '1; r.ev.key_lo = '1; r.ev.now = '1;     dir_tab = {dir_tab, r};
    r.ev.ip = 32'hC0A8_0001; r.ev.now = '0;                dir_tab = {dir_tab, r};
    r.ev.key_hi = '0;                                      dir_tab = {dir_tab, r};
    foreach (dir_tab[i]) send_event(dir_tab[i].ev, dir_tab[i].typed,
                                     dir_tab[i].status, dir_tab[i].not_stored);
    drain();

    clock_now = $urandom; step_max = 2;
    random_phase(120, 30);

    // Sweep every event, zero timeout, no minimum length
    snd_idle = 76; rcv_idle = 23;
    write_reg(CFG_MAGIC_TOKEN, {$urandom, $urandom});
    write_reg(CFG_MIN_LENGTH, 64'd0);
    write_reg(CFG_TIMEOUT_SECONDS, 64'd0);
    write_reg(CFG_CLEANUP_INTERVAL, 64'd0);
    step_max = 1;
    random_phase(80, -1);

    // Large settings: every packet is too short
    write_reg(CFG_MIN_LENGTH, 64'hFFFF);
    write_reg(CFG_TIMEOUT_SECONDS, 64'd86400);
    write_reg(CFG_CLEANUP_INTERVAL, 64'hFFFFF);
    write_reg(CFG_MAGIC_TOKEN, '1);
    random_phase(20, -1);

    // Frequent aging with a short timeout, no idling
    snd_idle = 0; rcv_idle = 0;
    write_reg(CFG_MAGIC_TOKEN, MagicReset);
    write_reg(CFG_MIN_LENGTH, 64'd100);
    write_reg(CFG_TIMEOUT_SECONDS, 64'd5);
    write_reg(CFG_CLEANUP_INTERVAL, 64'd3);
    step_max = 3;
    random_phase(130, -1);

    if (errors == 0) $display("session_relay_forwarding_table_core regression: pass");
    else $display("session_relay_forwarding_table_core regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/srft_pkg.sv
hdl/srft_ctrl.sv
hdl/srft_dp.sv
hdl/session_relay_forwarding_table_core.sv
tb/session_relay_forwarding_table_core_test.sv
